// File: rtl/script_token_scanner_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the script token scanner
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_SCANNER_CORE_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication
`define STSC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication
`define STSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/stsc_pkg.sv
// ----------------------------------------------------------------------------
// stsc_pkg
// Types, token codes and keyword table shared by the script token scanner.
// ----------------------------------------------------------------------------
package stsc_pkg;

  localparam int POSITION_BITS_DEF      = 16;
  localparam int KEYWORD_HEAD_CHARS_DEF = 8;

  localparam int TOK_W   = 16;  // width of token start and length fields
  localparam int VAL_W   = 63;  // width of the number value
  localparam int KIND_W  = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam int KW_COUNT   = 11;
  localparam int KW_MAX_LEN = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_EOF        = 5'd0,
    KIND_EOL        = 5'd1,
    KIND_NUMBER     = 5'd2,
    KIND_IDENT      = 5'd3,
    KIND_KW_PUSH    = 5'd4,
    KIND_KW_SET     = 5'd5,
    KIND_KW_REPEAT  = 5'd6,
    KIND_KW_END     = 5'd7,
    KIND_KW_JUMPIF  = 5'd8,
    KIND_KW_BREAKIF = 5'd9,
    KIND_KW_FN      = 5'd10,
    KIND_KW_ENDFN   = 5'd11,
    KIND_KW_ASM     = 5'd12,
    KIND_KW_MACRO   = 5'd13,
    KIND_KW_LABEL   = 5'd14,
    KIND_PLUS       = 5'd15,
    KIND_MINUS      = 5'd16,
    KIND_STAR       = 5'd17,
    KIND_SLASH      = 5'd18,
    KIND_EQ         = 5'd19,
    KIND_EQEQ       = 5'd20,
    KIND_COMMA      = 5'd21,
    KIND_COLON      = 5'd22,
    KIND_LPAREN     = 5'd23,
    KIND_RPAREN     = 5'd24,
    KIND_LBRACKET   = 5'd25,
    KIND_RBRACKET   = 5'd26
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE         = 3'd0,
    MODE_IDENT        = 3'd1,
    MODE_NUMBER       = 3'd2,
    MODE_EQ           = 3'd3,
    MODE_SLASH        = 3'd4,
    MODE_COMMENT      = 3'd5,
    MODE_COMMENT_STAR = 3'd6
  } mode_t;

  // Keyword text, right-justified: first character of keyword k sits at
  // bits [8*KW_LEN[k]-1 -: 8].
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    "push", "set", "repeat", "end", "jumpif", "breakif",
    "fn", "endfn", "asm", "@macro", "@label"
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd3, 3'd6, 3'd3, 3'd6, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd6
  };

  typedef struct packed {
    kind_t              kind;
    logic [TOK_W-1:0]   start;
    logic [TOK_W-1:0]   length;
    logic [VAL_W-1:0]   value;
    logic               last;
  } result_t;

endpackage

// File: rtl/script_token_scanner_core.sv
// ----------------------------------------------------------------------------
// script_token_scanner_core
// Streaming tokenizer: one source byte per item in, up to two tokens out.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_ch               | in
//  result  | out_valid, out_stall, out_token_kind,   | out
//          | out_token_start, out_token_length,      |
//          | out_number_value, out_last              |
//
// One byte is taken every cycle while in_stall is low; its tokens are written
// to a four-entry result queue in the same cycle and show on the result ports once they reach its head.
// A byte that yields two tokens takes two queue entries, so the byte rate
// falls below one per cycle only where the queue drains slower than it fills.
// in_stall rises when fewer than two queue entries are free.
// Reset (synchronous, rst_n low) empties the queue and returns to idle.
// ----------------------------------------------------------------------------
module script_token_scanner_core #(
  parameter int POSITION_BITS      = stsc_pkg::POSITION_BITS_DEF,
  parameter int KEYWORD_HEAD_CHARS = stsc_pkg::KEYWORD_HEAD_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_ch,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stsc_pkg::KIND_W-1:0] out_token_kind,
  output logic [stsc_pkg::TOK_W-1:0]  out_token_start,
  output logic [stsc_pkg::TOK_W-1:0]  out_token_length,
  output logic [stsc_pkg::VAL_W-1:0]  out_number_value,
  output logic                        out_last
);

  localparam int TW    = stsc_pkg::TOK_W;
  localparam int VW    = stsc_pkg::VAL_W;
  localparam int QD    = stsc_pkg::QUEUE_DEPTH;
  localparam int QP_W  = $clog2(QD);
  localparam int QC_W  = $clog2(QD + 1);

  // --------------------------------------------------------------------------
  // Scanner state
  // --------------------------------------------------------------------------
  stsc_pkg::mode_t            mode_r, mode_nxt;
  logic [TW-1:0]              len_r, len_nxt;
  logic [POSITION_BITS-1:0]   pos_r, pos_nxt;
  logic [POSITION_BITS-1:0]   start_r, start_nxt;
  logic [VW-1:0]              acc_r, acc_nxt;
  logic [7:0]                 head_r   [KEYWORD_HEAD_CHARS];
  logic [7:0]                 head_nxt [KEYWORD_HEAD_CHARS];

  // Result queue
  stsc_pkg::result_t          q_r [QD];
  logic [QP_W-1:0]            hd_r;
  logic [QC_W-1:0]            cnt_r;

  logic                       fire, pop;
  logic                       used;
  logic                       is_alpha, is_digit, is_ident_start, is_ident_cont, is_blank;
  logic                       is_eof, starts_lexeme;

  stsc_pkg::result_t          res0, res1, flush_tok, single_tok;
  logic                       flush_vld, single_vld;
  logic [1:0]                 res_cnt;

  logic [POSITION_BITS+TW-1:0] pos_ext, start_ext;
  logic [TW-1:0]              pos16, start16;
  logic [TW-1:0]              len_inc;
  logic [POSITION_BITS-1:0]   pos_inc;

  logic [VW+3:0]              acc_sum;
  logic [VW-1:0]              acc_step;

  logic [stsc_pkg::KIND_W-1:0] ident_kind;
  logic                       kw_hit;

  assign fire     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign in_stall = (cnt_r > QC_W'(QD - 2));

  // --------------------------------------------------------------------------
  // Character classes
  // --------------------------------------------------------------------------
  assign is_alpha       = (in_ch >= "a" && in_ch <= "z") || (in_ch >= "A" && in_ch <= "Z");
  assign is_digit       = (in_ch >= "0" && in_ch <= "9");
  assign is_ident_cont  = is_alpha || is_digit || (in_ch == "_");
  assign is_ident_start = is_alpha || (in_ch == "_") || (in_ch == "@");
  assign is_blank       = (in_ch == " ") || (in_ch == 8'h09) || (in_ch == 8'h0D);
  assign is_eof         = (in_ch == 8'h00);
  assign starts_lexeme  = is_ident_start || is_digit || (in_ch == "=") || (in_ch == "/");

  assign pos_ext   = {{TW{1'b0}}, pos_r};
  assign start_ext = {{TW{1'b0}}, start_r};
  assign pos16     = pos_ext[TW-1:0];
  assign start16   = start_ext[TW-1:0];

  assign len_inc = (len_r != {TW{1'b1}}) ? len_r + TW'(1) : len_r;
  assign pos_inc = (pos_r != {POSITION_BITS{1'b1}}) ? pos_r + POSITION_BITS'(1) : pos_r;

  // acc * 10 + digit, saturating at the top of the value range
  assign acc_sum  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {{VW{1'b0}}, in_ch[3:0]};
  assign acc_step = (|acc_sum[VW+3:VW]) ? {VW{1'b1}} : acc_sum[VW-1:0];

  // --------------------------------------------------------------------------
  // Keyword match on the stored identifier head
  // --------------------------------------------------------------------------
  always_comb begin : p_keyword
    logic m;
    kw_hit     = 1'b0;
    ident_kind = stsc_pkg::KIND_IDENT;
    for (int k = 0; k < stsc_pkg::KW_COUNT; k++) begin
      m = (len_r == TW'(stsc_pkg::KW_LEN[k]));
      for (int j = 0; j < stsc_pkg::KW_MAX_LEN; j++) begin
        if (j < int'(stsc_pkg::KW_LEN[k])) begin
          m = m && (head_r[j] ==
                    stsc_pkg::KW_TEXT[k][8*(int'(stsc_pkg::KW_LEN[k]) - 1 - j) +: 8]);
        end
      end
      if (m && !kw_hit) begin
        kw_hit     = 1'b1;
        ident_kind = stsc_pkg::KIND_W'(int'(stsc_pkg::KIND_KW_PUSH) + k);
      end
    end
  end

  // Does the pending lexeme take this byte?
  always_comb begin : p_used
    case (mode_r)
      stsc_pkg::MODE_IDENT:        used = is_ident_cont;
      stsc_pkg::MODE_NUMBER:       used = is_digit;
      stsc_pkg::MODE_EQ:           used = (in_ch == "=");
      stsc_pkg::MODE_SLASH:        used = (in_ch == "*");
      stsc_pkg::MODE_COMMENT:      used = !is_eof;
      stsc_pkg::MODE_COMMENT_STAR: used = !is_eof;
      default:                     used = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tokens caused by this byte
  // --------------------------------------------------------------------------
  always_comb begin : p_result
    flush_tok  = '0;
    flush_vld  = 1'b0;
    single_tok = '0;
    single_vld = 1'b0;

    // close the pending lexeme
    case (mode_r)
      stsc_pkg::MODE_IDENT: begin
        flush_vld        = !used;
        flush_tok.kind   = stsc_pkg::kind_t'(ident_kind);
        flush_tok.start  = start16;
        flush_tok.length = len_r;
      end
      stsc_pkg::MODE_NUMBER: begin
        flush_vld        = !used;
        flush_tok.kind   = stsc_pkg::KIND_NUMBER;
        flush_tok.start  = start16;
        flush_tok.length = len_r;
        flush_tok.value  = acc_r;
      end
      stsc_pkg::MODE_EQ: begin
        flush_vld        = 1'b1;
        flush_tok.kind   = used ? stsc_pkg::KIND_EQEQ : stsc_pkg::KIND_EQ;
        flush_tok.start  = start16;
        flush_tok.length = used ? TW'(2) : TW'(1);
      end
      stsc_pkg::MODE_SLASH: begin
        flush_vld        = !used;
        flush_tok.kind   = stsc_pkg::KIND_SLASH;
        flush_tok.start  = start16;
        flush_tok.length = TW'(1);
      end
      default: begin
        flush_vld = 1'b0;
      end
    endcase

    // token from the byte itself
    single_tok.start = pos16;
    single_tok.last  = 1'b1;
    if (!used) begin
      if (is_eof) begin
        single_vld        = 1'b1;
        single_tok.kind   = stsc_pkg::KIND_EOF;
        single_tok.length = '0;
      end else if (!is_blank && !starts_lexeme) begin
        single_vld        = 1'b1;
        single_tok.length = TW'(1);
        case (in_ch)
          8'h0A, ";": single_tok.kind = stsc_pkg::KIND_EOL;
          "+":        single_tok.kind = stsc_pkg::KIND_PLUS;
          "-":        single_tok.kind = stsc_pkg::KIND_MINUS;
          "*":        single_tok.kind = stsc_pkg::KIND_STAR;
          ",":        single_tok.kind = stsc_pkg::KIND_COMMA;
          ":":        single_tok.kind = stsc_pkg::KIND_COLON;
          "(":        single_tok.kind = stsc_pkg::KIND_LPAREN;
          ")":        single_tok.kind = stsc_pkg::KIND_RPAREN;
          "[":        single_tok.kind = stsc_pkg::KIND_LBRACKET;
          "]":        single_tok.kind = stsc_pkg::KIND_RBRACKET;
          default:    single_tok.kind = stsc_pkg::KIND_EOF;  // unknown byte
        endcase
      end
    end

    flush_tok.last = !single_vld;

    res0    = flush_vld ? flush_tok : single_tok;
    res1    = single_tok;
    res_cnt = 2'(flush_vld) + 2'(single_vld);
  end

  // --------------------------------------------------------------------------
  // Next scanner state
  // --------------------------------------------------------------------------
  always_comb begin : p_next
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_inc;
    for (int i = 0; i < KEYWORD_HEAD_CHARS; i++) begin
      head_nxt[i] = head_r[i];
    end

    if (used) begin
      case (mode_r)
        stsc_pkg::MODE_IDENT: begin
          for (int i = 0; i < KEYWORD_HEAD_CHARS; i++) begin
            if (len_r == TW'(i)) begin
              head_nxt[i] = in_ch;
            end
          end
          len_nxt = len_inc;
        end
        stsc_pkg::MODE_NUMBER: begin
          acc_nxt = acc_step;
          len_nxt = len_inc;
        end
        stsc_pkg::MODE_EQ:    mode_nxt = stsc_pkg::MODE_IDLE;
        stsc_pkg::MODE_SLASH: mode_nxt = stsc_pkg::MODE_COMMENT;
        stsc_pkg::MODE_COMMENT: begin
          if (in_ch == "*") begin
            mode_nxt = stsc_pkg::MODE_COMMENT_STAR;
          end
        end
        stsc_pkg::MODE_COMMENT_STAR: begin
          if (in_ch == "/") begin
            mode_nxt = stsc_pkg::MODE_IDLE;
          end else if (in_ch != "*") begin
            mode_nxt = stsc_pkg::MODE_COMMENT;
          end
        end
        default: mode_nxt = stsc_pkg::MODE_IDLE;
      endcase
    end else begin
      mode_nxt = stsc_pkg::MODE_IDLE;
      if (is_eof) begin
        // end of source: clear position and lexeme
        len_nxt = '0;
        pos_nxt = '0;
      end else if (is_ident_start) begin
        mode_nxt    = stsc_pkg::MODE_IDENT;
        start_nxt   = pos_r;
        len_nxt     = TW'(1);
        head_nxt[0] = in_ch;
      end else if (is_digit) begin
        mode_nxt  = stsc_pkg::MODE_NUMBER;
        start_nxt = pos_r;
        len_nxt   = TW'(1);
        acc_nxt   = {{(VW-4){1'b0}}, in_ch[3:0]};
      end else if (in_ch == "=") begin
        mode_nxt  = stsc_pkg::MODE_EQ;
        start_nxt = pos_r;
      end else if (in_ch == "/") begin
        mode_nxt  = stsc_pkg::MODE_SLASH;
        start_nxt = pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stsc_pkg::MODE_IDLE;
      len_r  <= '0;
      pos_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      start_r <= start_nxt;
      acc_r   <= acc_nxt;
      for (int i = 0; i < KEYWORD_HEAD_CHARS; i++) begin
        head_r[i] <= head_nxt[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  logic [QP_W-1:0] wp0, wp1;
  logic [1:0]      push_n;

  assign wp0    = hd_r + cnt_r[QP_W-1:0];
  assign wp1    = wp0 + QP_W'(1);
  assign push_n = fire ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (pop) begin
        hd_r <= hd_r + QP_W'(1);
      end
      cnt_r <= cnt_r + QC_W'(push_n) - QC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wp0] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[wp1] <= res1;
    end
  end

  assign out_valid        = (cnt_r != '0);
  assign out_token_kind   = q_r[hd_r].kind;
  assign out_token_start  = q_r[hd_r].start;
  assign out_token_length = q_r[hd_r].length;
  assign out_number_value = q_r[hd_r].value;
  assign out_last         = q_r[hd_r].last;

endmodule

// File: rtl/stsc_port_check.sv
// ----------------------------------------------------------------------------
// stsc_port_check
// Port-level checks on the script token scanner, bound into script_token_scanner_core.
// ----------------------------------------------------------------------------
`include "script_token_scanner_core_assert.svh"

module stsc_port_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [7:0]                  in_ch,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [stsc_pkg::KIND_W-1:0] out_token_kind,
  input logic [stsc_pkg::TOK_W-1:0]  out_token_start,
  input logic [stsc_pkg::TOK_W-1:0]  out_token_length,
  input logic [stsc_pkg::VAL_W-1:0]  out_number_value,
  input logic                        out_last
);

  logic out_hold;
  logic in_seen;

  assign out_hold = out_valid && out_stall;
  assign in_seen  = in_valid && !in_stall && (in_ch != 8'hFF || in_ch == 8'hFF);

  // stalled result holds
  `STSC_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_token_kind) && $stable(out_token_start) && $stable(out_token_length) && $stable(out_number_value) && $stable(out_last), "stalled result changed")

  `STSC_ASSERT_NOW(a_kind_range, out_valid, out_token_kind <= stsc_pkg::KIND_RBRACKET, "token kind out of range")

  // only number tokens carry a value
  `STSC_ASSERT_NOW(a_value_zero, out_valid && (out_token_kind != stsc_pkg::KIND_NUMBER), out_number_value == '0, "value on non-number token")

  // end of source closes its byte
  `STSC_ASSERT_NOW(a_eof_last, out_valid && (out_token_kind == stsc_pkg::KIND_EOF) && (out_token_length == '0), out_last, "end-of-source token not last")

  // a byte accepted while the queue is empty always leaves room behind it
  `STSC_ASSERT_NEXT(a_accept_room, in_seen && !out_valid, out_valid || !in_stall, "queue full after empty")

endmodule

bind script_token_scanner_core stsc_port_check u_stsc_port_check (.*);
